// File: hdl/template_frame_boundary_detector_assert.svh
// Assertion macros shared by the frame boundary detector modules.
// Needs nothing else; each macro expands to one concurrent assertion.
`ifndef TEMPLATE_FRAME_BOUNDARY_DETECTOR_ASSERT_SVH
`define TEMPLATE_FRAME_BOUNDARY_DETECTOR_ASSERT_SVH

// Property that must hold at every clock edge out of reset
`define TFBD_CHECK(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define TFBD_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TFBD_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tfbd_pkg.sv
// Shared types and constants for the template frame boundary detector.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
package tfbd_pkg;

    // Default geometry and frame limits
    localparam int MAX_FRAMES_DEF = 1024;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // SAD accumulator width and saturation value
    localparam int SUM_W = 40;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int GEOM_W  = 13;
    localparam int POS_W   = 11;
    localparam int CLIP_W  = 12;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [GEOM_W-1:0] WIDTH_RST  = 13'd1920;
    localparam logic [GEOM_W-1:0] HEIGHT_RST = 13'd1080;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_START_LIMIT  = 2'd2,
        REG_END_LIMIT    = 2'd3
    } reg_idx_t;

    // One input beat
    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] end_ref;
        logic [PIX_W-1:0] start_ref;
        logic [PIX_W-1:0] pixel;
    } beat_t;

    // Luma SAD limits
    typedef struct packed {
        logic [SUM_W-1:0] start_luma_limit;
        logic [SUM_W-1:0] end_luma_limit;
    } lim_t;

    // Pipeline token: frame marks a completed frame (stage 1) or a pending
    // decision (stage 2)
    typedef struct packed {
        logic valid;
        logic last;
        logic frame;
    } tok_t;

    // Final sums of one frame
    typedef struct packed {
        logic [SUM_W-1:0] sl;
        logic [SUM_W-1:0] el;
        logic [SUM_W-1:0] sc;
        logic [SUM_W-1:0] ec;
    } fsums_t;

    // Result beat
    typedef struct packed {
        logic [POS_W-1:0]         frame_total;
        logic signed [CLIP_W-1:0] clip_length;
        logic [POS_W-1:0]         end_frame;
        logic [POS_W-1:0]         start_frame;
    } res_t;

endpackage

// File: hdl/tfbd_cfg.sv
// Configuration registers and derived frame geometry (luma and total bytes).
// Depends on tfbd_pkg.
module tfbd_cfg #(
    parameter int MAX_WIDTH  = tfbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tfbd_pkg::MAX_HEIGHT_DEF,
    localparam int WW      = $clog2(MAX_WIDTH + 1),
    localparam int HW      = $clog2(MAX_HEIGHT + 1),
    localparam int LUMA_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    localparam int TOTAL_W = $clog2(MAX_WIDTH * MAX_HEIGHT * 3 / 2 + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [tfbd_pkg::DATA_W-1:0]   pwdata,
    output logic [tfbd_pkg::DATA_W-1:0]   prdata,
    output tfbd_pkg::lim_t                lim,
    output logic [LUMA_W-1:0]             luma,
    output logic [TOTAL_W-1:0]            total
);

    logic [tfbd_pkg::GEOM_W-1:0] width_reg, height_reg;
    logic [tfbd_pkg::SUM_W-1:0]  start_lim_reg, end_lim_reg;
    logic [LUMA_W-1:0]           luma_reg, luma_next;
    logic [TOTAL_W-1:0]          total_reg, total_next;
    logic [WW-1:0]               w_clamp;
    logic [HW-1:0]               h_clamp;
    tfbd_pkg::reg_idx_t          idx;
    logic                        wr_en;

    assign idx   = tfbd_pkg::reg_idx_t'(paddr[4:3]);
    assign wr_en = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= tfbd_pkg::WIDTH_RST;
            height_reg    <= tfbd_pkg::HEIGHT_RST;
            start_lim_reg <= tfbd_pkg::SUM_MAX;
            end_lim_reg   <= tfbd_pkg::SUM_MAX;
        end
        else if (wr_en)
        begin
            case (idx)
                tfbd_pkg::REG_FRAME_WIDTH:  width_reg     <= pwdata[tfbd_pkg::GEOM_W-1:0];
                tfbd_pkg::REG_FRAME_HEIGHT: height_reg    <= pwdata[tfbd_pkg::GEOM_W-1:0];
                tfbd_pkg::REG_START_LIMIT:  start_lim_reg <= pwdata[tfbd_pkg::SUM_W-1:0];
                tfbd_pkg::REG_END_LIMIT:    end_lim_reg   <= pwdata[tfbd_pkg::SUM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            tfbd_pkg::REG_FRAME_WIDTH:  prdata = tfbd_pkg::DATA_W'(width_reg);
            tfbd_pkg::REG_FRAME_HEIGHT: prdata = tfbd_pkg::DATA_W'(height_reg);
            tfbd_pkg::REG_START_LIMIT:  prdata = tfbd_pkg::DATA_W'(start_lim_reg);
            tfbd_pkg::REG_END_LIMIT:    prdata = tfbd_pkg::DATA_W'(end_lim_reg);
            default:                    prdata = '0;
        endcase
    end

    // Clamp geometry, then luma = w*h and total = 1.5 * luma
    always_comb
    begin
        if (width_reg == '0)
            w_clamp = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(width_reg);

        if (32'(height_reg) < 32'd2)
            h_clamp = HW'(2);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(height_reg);

        luma_next  = LUMA_W'(w_clamp) * LUMA_W'(h_clamp);
        total_next = TOTAL_W'(luma_reg) + TOTAL_W'(luma_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_reg  <= LUMA_W'(1920 * 1080);
            total_reg <= TOTAL_W'(1920 * 1080 * 3 / 2);
        end
        else
        begin
            luma_reg  <= luma_next;
            total_reg <= total_next;
        end
    end

    assign lim.start_luma_limit = start_lim_reg;
    assign lim.end_luma_limit   = end_lim_reg;
    assign luma  = luma_reg;
    assign total = total_reg;

endmodule

// File: hdl/tfbd_accum.sv
// Per-byte stage: byte position in the frame and the four saturating SAD sums.
// Depends on tfbd_pkg and the assertion header.
`include "template_frame_boundary_detector_assert.svh"

module tfbd_accum #(
    parameter int MAX_WIDTH  = tfbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tfbd_pkg::MAX_HEIGHT_DEF,
    localparam int LUMA_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    localparam int TOTAL_W = $clog2(MAX_WIDTH * MAX_HEIGHT * 3 / 2 + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  tfbd_pkg::beat_t      in_beat,
    input  logic [LUMA_W-1:0]    luma,
    input  logic [TOTAL_W-1:0]   total,
    output tfbd_pkg::tok_t       s1_tok,
    output tfbd_pkg::fsums_t     s1_sums
);

    localparam int SW = tfbd_pkg::SUM_W;

    logic [TOTAL_W-1:0] bidx_reg, bidx_next;
    logic [SW-1:0]      sl_reg, el_reg, sc_reg, ec_reg;
    logic [SW-1:0]      sl_next, el_next, sc_next, ec_next;
    logic [SW-1:0]      sl_new, el_new, sc_new, ec_new;
    logic [7:0]         d_s, d_e;
    logic               is_luma, frame_end, step;
    tfbd_pkg::tok_t     tok_reg;
    tfbd_pkg::fsums_t   sums_reg;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [7:0] d);
        logic [SW:0] t;
        t = {1'b0, s} + (SW + 1)'(d);
        sat_add = t[SW] ? tfbd_pkg::SUM_MAX : t[SW-1:0];
    endfunction

    // Accumulate into luma or chroma sums, detect last byte of the frame
    always_comb
    begin
        step      = advance && in_valid;
        d_s       = absdiff8(in_beat.pixel, in_beat.start_ref);
        d_e       = absdiff8(in_beat.pixel, in_beat.end_ref);
        is_luma   = bidx_reg < TOTAL_W'(luma);
        frame_end = ({1'b0, bidx_reg} + (TOTAL_W + 1)'(1)) >= {1'b0, total};

        sl_new = is_luma ? sat_add(sl_reg, d_s) : sl_reg;
        el_new = is_luma ? sat_add(el_reg, d_e) : el_reg;
        sc_new = is_luma ? sc_reg : sat_add(sc_reg, d_s);
        ec_new = is_luma ? ec_reg : sat_add(ec_reg, d_e);

        bidx_next = bidx_reg;
        sl_next   = sl_reg;
        el_next   = el_reg;
        sc_next   = sc_reg;
        ec_next   = ec_reg;
        if (step)
        begin
            if (frame_end || in_beat.last)
            begin
                bidx_next = '0;
                sl_next   = '0;
                el_next   = '0;
                sc_next   = '0;
                ec_next   = '0;
            end
            else
            begin
                bidx_next = bidx_reg + TOTAL_W'(1);
                sl_next   = sl_new;
                el_next   = el_new;
                sc_next   = sc_new;
                ec_next   = ec_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bidx_reg <= '0;
            sl_reg   <= '0;
            el_reg   <= '0;
            sc_reg   <= '0;
            ec_reg   <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            bidx_reg <= bidx_next;
            sl_reg   <= sl_next;
            el_reg   <= el_next;
            sc_reg   <= sc_next;
            ec_reg   <= ec_next;
            if (advance)
            begin
                tok_reg.valid <= in_valid;
                tok_reg.last  <= in_beat.last;
                tok_reg.frame <= frame_end;
            end
        end
    end

    // Completed frame sums, payload only
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sums_reg.sl <= sl_new;
            sums_reg.el <= el_new;
            sums_reg.sc <= sc_new;
            sums_reg.ec <= ec_new;
        end
    end

    assign s1_tok  = tok_reg;
    assign s1_sums = sums_reg;

    `TFBD_NEXT(a_bidx_restart, clk, rst_n, step && (frame_end || in_beat.last), bidx_reg == '0, "byte index not restarted after frame end or last beat")

endmodule

// File: hdl/tfbd_decide.sv
// Per-frame stages: chroma jump computation, then start/end decision and result.
// Depends on tfbd_pkg and the assertion header.
`include "template_frame_boundary_detector_assert.svh"

module tfbd_decide #(
    parameter int MAX_FRAMES = tfbd_pkg::MAX_FRAMES_DEF,
    localparam int FCW = $clog2(MAX_FRAMES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  tfbd_pkg::tok_t     s1_tok,
    input  tfbd_pkg::fsums_t   s1_sums,
    input  tfbd_pkg::lim_t     lim,
    output tfbd_pkg::tok_t     s2_tok,
    output tfbd_pkg::res_t     res
);

    localparam int SW = tfbd_pkg::SUM_W;

    // Stage B state
    logic [SW-1:0]  prev_sc_reg, prev_ec_reg, prev_sl_reg;
    logic [SW-1:0]  prev_sc_next, prev_ec_next, prev_sl_next;
    logic [FCW-1:0] frame_cnt_reg, frame_cnt_next, cnt_upd;
    logic           take;
    logic [SW-1:0]  sj, ej;

    // Stage 2 pipeline register
    tfbd_pkg::tok_t tok2_reg;
    logic [FCW-1:0] k2_reg, cnt2_reg;
    logic [SW-1:0]  sj2_reg, ej2_reg, psl2_reg, el2_reg;

    // Stage C state
    logic [SW-1:0]  best_sj_reg, best_ej_reg, best_sl_reg, best_el_reg;
    logic [SW-1:0]  best_sj_next, best_ej_next, best_sl_next, best_el_next;
    logic [SW-1:0]  best_sj_upd, best_ej_upd, best_sl_upd, best_el_upd;
    logic [FCW-1:0] start_pos_reg, end_pos_reg, start_pos_next, end_pos_next;
    logic [FCW-1:0] start_pos_upd, end_pos_upd, endv;
    logic           end_found_reg, end_found_next, end_found_upd;
    logic           sgt, start_ok, end_ok;

    function automatic logic [SW-1:0] absdiff(input logic [SW-1:0] a, input logic [SW-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Stage B: chroma jumps against the previous frame, frame counting
    always_comb
    begin
        take    = s1_tok.frame && (frame_cnt_reg < FCW'(MAX_FRAMES));
        sj      = absdiff(prev_sc_reg, s1_sums.sc);
        ej      = absdiff(prev_ec_reg, s1_sums.ec);
        cnt_upd = take ? (frame_cnt_reg + FCW'(1)) : frame_cnt_reg;

        prev_sc_next   = prev_sc_reg;
        prev_ec_next   = prev_ec_reg;
        prev_sl_next   = prev_sl_reg;
        frame_cnt_next = frame_cnt_reg;
        if (advance && s1_tok.valid)
        begin
            if (s1_tok.last)
            begin
                prev_sc_next   = '0;
                prev_ec_next   = '0;
                prev_sl_next   = '0;
                frame_cnt_next = '0;
            end
            else if (take)
            begin
                prev_sc_next   = s1_sums.sc;
                prev_ec_next   = s1_sums.ec;
                prev_sl_next   = s1_sums.sl;
                frame_cnt_next = cnt_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sc_reg   <= '0;
            prev_ec_reg   <= '0;
            prev_sl_reg   <= '0;
            frame_cnt_reg <= '0;
            tok2_reg      <= '0;
        end
        else
        begin
            prev_sc_reg   <= prev_sc_next;
            prev_ec_reg   <= prev_ec_next;
            prev_sl_reg   <= prev_sl_next;
            frame_cnt_reg <= frame_cnt_next;
            if (advance)
            begin
                tok2_reg.valid <= s1_tok.valid;
                tok2_reg.last  <= s1_tok.last;
                tok2_reg.frame <= take && (frame_cnt_reg != '0);
            end
        end
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            k2_reg   <= frame_cnt_reg;
            cnt2_reg <= cnt_upd;
            sj2_reg  <= sj;
            ej2_reg  <= ej;
            psl2_reg <= prev_sl_reg;
            el2_reg  <= s1_sums.el;
        end
    end

    // Stage C: pick start or end candidate, gate by luma limits and minima
    always_comb
    begin
        sgt      = sj2_reg > ej2_reg;
        start_ok = (best_sj_reg <= sj2_reg) && (best_sl_reg >= psl2_reg) &&
                   (psl2_reg <= lim.start_luma_limit);
        end_ok   = (best_ej_reg <= ej2_reg) && (best_el_reg >= el2_reg) &&
                   (el2_reg <= lim.end_luma_limit);

        best_sj_upd   = best_sj_reg;
        best_ej_upd   = best_ej_reg;
        best_sl_upd   = best_sl_reg;
        best_el_upd   = best_el_reg;
        start_pos_upd = start_pos_reg;
        end_pos_upd   = end_pos_reg;
        end_found_upd = end_found_reg;
        if (tok2_reg.frame)
        begin
            if (sgt)
            begin
                if (start_ok)
                begin
                    best_sj_upd   = sj2_reg;
                    best_sl_upd   = psl2_reg;
                    start_pos_upd = k2_reg;
                    // new start at or past the end: lift the luma bound for a later end
                    if (end_found_reg && (k2_reg >= end_pos_reg))
                        best_el_upd = tfbd_pkg::SUM_MAX;
                end
            end
            else if (end_ok)
            begin
                best_ej_upd   = ej2_reg;
                best_el_upd   = el2_reg;
                end_pos_upd   = k2_reg;
                end_found_upd = 1'b1;
            end
        end

        best_sj_next   = best_sj_reg;
        best_ej_next   = best_ej_reg;
        best_sl_next   = best_sl_reg;
        best_el_next   = best_el_reg;
        start_pos_next = start_pos_reg;
        end_pos_next   = end_pos_reg;
        end_found_next = end_found_reg;
        if (advance && tok2_reg.valid)
        begin
            if (tok2_reg.last)
            begin
                best_sj_next   = '0;
                best_ej_next   = '0;
                best_sl_next   = tfbd_pkg::SUM_MAX;
                best_el_next   = tfbd_pkg::SUM_MAX;
                start_pos_next = '0;
                end_pos_next   = '0;
                end_found_next = 1'b0;
            end
            else
            begin
                best_sj_next   = best_sj_upd;
                best_ej_next   = best_ej_upd;
                best_sl_next   = best_sl_upd;
                best_el_next   = best_el_upd;
                start_pos_next = start_pos_upd;
                end_pos_next   = end_pos_upd;
                end_found_next = end_found_upd;
            end
        end

        // Result from the state after this beat's decision
        endv            = end_found_upd ? end_pos_upd : cnt2_reg;
        res.start_frame = tfbd_pkg::POS_W'(start_pos_upd);
        res.end_frame   = tfbd_pkg::POS_W'(endv);
        res.clip_length = tfbd_pkg::CLIP_W'(endv) - tfbd_pkg::CLIP_W'(start_pos_upd);
        res.frame_total = tfbd_pkg::POS_W'(cnt2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sj_reg   <= '0;
            best_ej_reg   <= '0;
            best_sl_reg   <= tfbd_pkg::SUM_MAX;
            best_el_reg   <= tfbd_pkg::SUM_MAX;
            start_pos_reg <= '0;
            end_pos_reg   <= '0;
            end_found_reg <= 1'b0;
        end
        else
        begin
            best_sj_reg   <= best_sj_next;
            best_ej_reg   <= best_ej_next;
            best_sl_reg   <= best_sl_next;
            best_el_reg   <= best_el_next;
            start_pos_reg <= start_pos_next;
            end_pos_reg   <= end_pos_next;
            end_found_reg <= end_found_next;
        end
    end

    assign s2_tok = tok2_reg;

    `TFBD_CHECK(a_frame_cnt_max, clk, rst_n, frame_cnt_reg <= FCW'(MAX_FRAMES), "frame count beyond limit")
    `TFBD_IMPLIES(a_end_pos_clear, clk, rst_n, !end_found_reg, end_pos_reg == '0, "end position set without end found")

endmodule

// File: hdl/template_frame_boundary_detector.sv
// Template frame boundary detector, top level: ports, input and result beats.
// Depends on tfbd_pkg, tfbd_cfg, tfbd_accum, tfbd_decide and the assertion header.
//
// Usage:
//   s_* stream: one video byte per beat with the co-located start and end
//   template bytes; s_tlast marks the final byte of the video.
//   m_* stream: one result beat per s_tlast beat (start, end, length, count).
//   APB port: frame_width, frame_height and the two luma SAD limits at
//   byte addresses 0, 8, 16 and 24; write only while the block is idle.
// Timing:
//   One byte per cycle while the pipeline does not hold (see Stall). A beat
//   passes an input register, the byte accumulate stage, the jump stage and
//   the decision stage; the result for a last beat is then registered onto m_tvalid.
//   A new geometry reaches the datapath through the registered luma, then the registered total.
// Reset: all sums, counters and positions clear; registers take their
//   defaults (1920 x 1080, limits all ones). No beat is lost or replayed.
// Stall: while m_tready is low the result beat holds. Input beats keep
//   flowing until a further last beat reaches the decision stage; the
//   pipeline then holds until the pending result is taken.
`include "template_frame_boundary_detector_assert.svh"

module template_frame_boundary_detector #(
    parameter int MAX_FRAMES = tfbd_pkg::MAX_FRAMES_DEF,
    parameter int MAX_WIDTH  = tfbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tfbd_pkg::MAX_HEIGHT_DEF,
    localparam int LUMA_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    localparam int TOTAL_W = $clog2(MAX_WIDTH * MAX_HEIGHT * 3 / 2 + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // slave stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,  // pixel, start_ref, end_ref
    input  logic                         s_tlast,
    // master stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,  // start_frame, end_frame, clip_length,
                                                   // frame_total, zero pad
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tfbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [tfbd_pkg::DATA_W-1:0]  pwdata,
    output logic [tfbd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    tfbd_pkg::lim_t    lim;
    logic [LUMA_W-1:0] luma;
    logic [TOTAL_W-1:0] total;

    logic              s0_valid_reg;
    tfbd_pkg::beat_t   s0_beat_reg;
    tfbd_pkg::tok_t    s1_tok, s2_tok;
    tfbd_pkg::fsums_t  s1_sums;
    tfbd_pkg::res_t    res;
    logic              advance;

    logic              out_valid_reg;
    tfbd_pkg::res_t    out_res_reg;

    assign pready = 1'b1;

    tfbd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .lim     (lim),
        .luma    (luma),
        .total   (total)
    );

    // Pipeline holds only when a result is due and the output beat is still held
    assign advance  = !(s2_tok.valid && s2_tok.last && out_valid_reg && !m_tready);
    assign s_tready = advance || !s0_valid_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s_tready)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s0_beat_reg.pixel     <= s_tdata[7:0];
            s0_beat_reg.start_ref <= s_tdata[15:8];
            s0_beat_reg.end_ref   <= s_tdata[23:16];
            s0_beat_reg.last      <= s_tlast;
        end
    end

    tfbd_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s0_valid_reg),
        .in_beat  (s0_beat_reg),
        .luma     (luma),
        .total    (total),
        .s1_tok   (s1_tok),
        .s1_sums  (s1_sums)
    );

    tfbd_decide #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_decide (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .s1_tok  (s1_tok),
        .s1_sums (s1_sums),
        .lim     (lim),
        .s2_tok  (s2_tok),
        .res     (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && s2_tok.valid && s2_tok.last)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_tok.valid && s2_tok.last)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.frame_total, out_res_reg.clip_length,
                       out_res_reg.end_frame, out_res_reg.start_frame};

    `TFBD_IMPLIES(a_result_source, clk, rst_n, $rose(out_valid_reg), $past(s2_tok.valid && s2_tok.last), "result beat without a last beat at the decision stage")

endmodule

// File: dv/tb_top.sv
// Self-checking bench for template_frame_boundary_detector: random and directed
// byte streams against an in-bench predictor. Needs tfbd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import tfbd_pkg::*;

    localparam int FRAME_CAP  = MAX_FRAMES_DEF;
    localparam int WIDTH_CAP  = MAX_WIDTH_DEF;
    localparam int HEIGHT_CAP = MAX_HEIGHT_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 8;

    // Content of one frame in a generated clip
    typedef enum int {FILL_NOISE, FILL_START, FILL_END, FILL_FLAT} fill_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata = '0;   // pixel, start_ref, end_ref
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;        // start_frame, end_frame, clip_length,
                                        // frame_total, zero pad
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    template_frame_boundary_detector u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Bench bookkeeping
    res_t pending_results[$];
    int   errors = 0;
    int   bytes_sent = 0;
    int   results_due = 0;
    int   src_idle_pct = 13;
    int   snk_idle_pct = 80;
    int   quiet_cycles = 0;
    res_t rx_got, rx_want;

    // Predictor copy of the registers
    logic [GEOM_W-1:0] cfg_width  = WIDTH_RST;
    logic [GEOM_W-1:0] cfg_height = HEIGHT_RST;
    logic [SUM_W-1:0]  cfg_slimit = SUM_MAX;
    logic [SUM_W-1:0]  cfg_elimit = SUM_MAX;

    // Predictor copy of the per-clip state
    longint            pos_in_frame;
    int                frames_done;
    logic [SUM_W-1:0]  sad_sl, sad_el, sad_sc, sad_ec;
    logic [SUM_W-1:0]  last_sc, last_ec, last_sl;
    logic [SUM_W-1:0]  top_sjump, top_ejump, top_sluma, top_eluma;
    int                start_at, end_at;
    bit                end_seen;

    // Clock and reset
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [SUM_W-1:0] sat_acc(logic [SUM_W-1:0] acc, logic [7:0] d);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + d;
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] gap40(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Luma bytes per frame after clamping the geometry
    function automatic longint luma_bytes();
        longint w, h;
        w = cfg_width;
        h = cfg_height;
        if (w < 1) w = 1;
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        if (h < 2) h = 2;
        if (h > HEIGHT_CAP) h = HEIGHT_CAP;
        return w * h;
    endfunction

    function automatic void clear_clip_state();
        pos_in_frame = 0;
        frames_done  = 0;
        sad_sl = '0; sad_el = '0; sad_sc = '0; sad_ec = '0;
        last_sc = '0; last_ec = '0; last_sl = '0;
        top_sjump = '0; top_ejump = '0;
        top_sluma = SUM_MAX; top_eluma = SUM_MAX;
        start_at = 0; end_at = 0;
        end_seen = 1'b0;
    endfunction

    // Frame boundary decision on the chroma jumps of the frame just closed
    function automatic void close_frame();
        logic [SUM_W-1:0] sj, ej;
        if (frames_done >= FRAME_CAP)
            return;
        if (frames_done >= 1)
        begin
            sj = gap40(last_sc, sad_sc);
            ej = gap40(last_ec, sad_ec);
            if (sj > ej)
            begin
                if (top_sjump <= sj && top_sluma >= last_sl && last_sl <= cfg_slimit)
                begin
                    top_sjump = sj;
                    top_sluma = last_sl;
                    start_at  = frames_done;
                    if (end_seen && start_at >= end_at)
                        top_eluma = SUM_MAX;
                end
            end
            else if (top_ejump <= ej && top_eluma >= sad_el && sad_el <= cfg_elimit)
            begin
                top_ejump = ej;
                top_eluma = sad_el;
                end_at    = frames_done;
                end_seen  = 1'b1;
            end
        end
        last_sc = sad_sc;
        last_ec = sad_ec;
        last_sl = sad_sl;
        frames_done++;
    endfunction

    // Advance the predictor by one byte; returns 1 when a result is due
    function automatic bit predict_byte(input beat_t b, output res_t r);
        longint luma, fsize;
        int     endv, diff;
        luma  = luma_bytes();
        fsize = luma * 3 / 2;
        r = '0;
        if (pos_in_frame < luma)
        begin
            sad_sl = sat_acc(sad_sl, (b.pixel > b.start_ref) ? b.pixel - b.start_ref
                                                             : b.start_ref - b.pixel);
            sad_el = sat_acc(sad_el, (b.pixel > b.end_ref) ? b.pixel - b.end_ref
                                                           : b.end_ref - b.pixel);
        end
        else
        begin
            sad_sc = sat_acc(sad_sc, (b.pixel > b.start_ref) ? b.pixel - b.start_ref
                                                             : b.start_ref - b.pixel);
            sad_ec = sat_acc(sad_ec, (b.pixel > b.end_ref) ? b.pixel - b.end_ref
                                                           : b.end_ref - b.pixel);
        end
        if (pos_in_frame + 1 >= fsize)
        begin
            close_frame();
            pos_in_frame = 0;
            sad_sl = '0; sad_el = '0; sad_sc = '0; sad_ec = '0;
        end
        else
            pos_in_frame++;
        if (!b.last)
            return 1'b0;
        endv = end_seen ? end_at : frames_done;
        diff = endv - start_at;
        r.start_frame = start_at[POS_W-1:0];
        r.end_frame   = endv[POS_W-1:0];
        r.clip_length = diff[CLIP_W-1:0];
        r.frame_total = frames_done[POS_W-1:0];
        clear_clip_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Receiver backpressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // One input beat, with random sender gaps before it
    task automatic send_beat(logic [7:0] px, logic [7:0] sr, logic [7:0] er, logic lst);
        beat_t b;
        res_t  r;
        b.pixel     = px;
        b.start_ref = sr;
        b.end_ref   = er;
        b.last      = lst;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b[23:0];
        s_tlast  <= b.last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        if (predict_byte(b, r))
        begin
            pending_results.push_back(r);
            results_due++;
        end
    endtask

    // Drop valid, wait for every result, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic reg_check(reg_idx_t idx, logic [DATA_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $display("%0t reg %s: expected %h, got %h", $time, idx.name(), want, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Register write followed by a read back
    task automatic reg_set(reg_idx_t idx, logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] kept;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = val[GEOM_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = val[GEOM_W-1:0];
            REG_START_LIMIT:  cfg_slimit = val[SUM_W-1:0];
            default:          cfg_elimit = val[SUM_W-1:0];
        endcase
        kept = (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT)
             ? {{(DATA_W-GEOM_W){1'b0}}, val[GEOM_W-1:0]}
             : {{(DATA_W-SUM_W){1'b0}}, val[SUM_W-1:0]};
        reg_check(idx, kept);
    endtask

    function automatic logic [SUM_W-1:0] rand_limit();
        case ($urandom_range(3))
            0:       return '0;
            1:       return SUM_MAX;
            2:       return SUM_W'($urandom_range(2000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic set_geometry(logic [GEOM_W-1:0] w, logic [GEOM_W-1:0] h);
        reg_set(REG_FRAME_WIDTH, w);
        reg_set(REG_FRAME_HEIGHT, h);
        reg_set(REG_START_LIMIT, rand_limit());
        reg_set(REG_END_LIMIT, rand_limit());
    endtask

    // A clip of whole frames plus a partial tail; last on the final byte
    task automatic send_clip(int n_frames, int extra);
        longint     fsize, n;
        fill_t      fill;
        logic [7:0] px, sr, er, flat;
        fsize = luma_bytes() * 3 / 2;
        n = n_frames * fsize + extra;
        if (n == 0)
            n = 1;
        fill = FILL_NOISE;
        flat = '0;
        for (longint i = 0; i < n; i++)
        begin
            if (i % fsize == 0)
            begin
                fill = fill_t'($urandom_range(3));
                flat = $urandom_range(255);
            end
            sr = $urandom_range(255);
            er = $urandom_range(255);
            case (fill)
                FILL_START: px = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : sr;
                FILL_END:   px = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : er;
                FILL_FLAT:  px = flat;
                default:    px = $urandom_range(255);
            endcase
            send_beat(px, sr, er, i == n - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        reg_check(REG_FRAME_WIDTH, WIDTH_RST);
        reg_check(REG_FRAME_HEIGHT, HEIGHT_RST);
        reg_check(REG_START_LIMIT, SUM_MAX);
        reg_check(REG_END_LIMIT, SUM_MAX);
    endtask

    // 1x2 frames: two luma bytes and one chroma byte each
    task automatic test_directed();
        reg_set(REG_FRAME_WIDTH, 1);
        reg_set(REG_FRAME_HEIGHT, 2);
        // lone last byte: partial frame only
        send_beat(8'hFF, 8'h00, 8'h00, 1'b1);
        // start jump on frame 1, end jump on frame 2
        send_beat(8'hFF, 8'h00, 8'h00, 1'b0);
        send_beat(8'h00, 8'hFF, 8'hFF, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'h80, 8'h00, 8'hFF, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'hFF, 8'h80, 8'h00, 1'b1);
        // end jump on frame 1 and no start: length 1; partial tail dropped
        send_beat(8'hA5, 8'h5A, 8'hA5, 1'b0);
        send_beat(8'h5A, 8'hA5, 8'h5A, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'hFF, 8'h00, 8'h00, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'h80, 8'h00, 8'hFF, 1'b0);
        send_beat(8'h56, 8'h34, 8'h12, 1'b1);
        settle();
    endtask

    // Clamped and largest geometries, few frames each
    task automatic test_geometry_extremes();
        set_geometry(13'd0, 13'd0);
        send_clip(4, 1);
        settle();
        set_geometry(13'd1, 13'd1);
        send_clip(3, 0);
        settle();
        set_geometry(13'd3, 13'd3);
        send_clip(4, 5);
        settle();
        set_geometry(13'h1FFF, 13'd2);
        send_clip(2, 0);
        settle();
        set_geometry(WIDTH_CAP, 13'd2);
        send_clip(1, 1);
        settle();
        set_geometry(13'd1, 13'h1FFF);
        send_clip(2, 0);
        settle();
        set_geometry(13'd1, HEIGHT_CAP);
        send_clip(1, 5);
        settle();
    endtask

    // More frames than the counter holds
    task automatic test_frame_limit();
        reg_set(REG_FRAME_WIDTH, 1);
        reg_set(REG_FRAME_HEIGHT, 2);
        reg_set(REG_START_LIMIT, 0);
        reg_set(REG_END_LIMIT, 0);
        send_clip(FRAME_CAP + 6, 2);
        settle();
    endtask

    // Random clips on small geometries with random registers
    task automatic test_random(int pct_src, int pct_snk, int n_bytes);
        int  byte_goal, result_goal, fsize;
        logic [GEOM_W-1:0] w, h;
        src_idle_pct = pct_src;
        snk_idle_pct = pct_snk;
        byte_goal    = bytes_sent + n_bytes;
        result_goal  = results_due + 16;
        while (bytes_sent < byte_goal || results_due < result_goal)
        begin
            if ($urandom_range(1) == 0)
            begin
                settle();
                w = ($urandom_range(15) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
                h = ($urandom_range(15) == 0) ? 13'($urandom_range(1))
                                              : 13'($urandom_range(2, 4));
                set_geometry(w, h);
            end
            fsize = int'(luma_bytes() * 3 / 2);
            send_clip($urandom_range(0, 8),
                      ($urandom_range(3) == 0) ? $urandom_range(0, fsize - 1) : 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
        $display("%0t %s: expected %h, got %h", $time, field, want, got);
        errors++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result beat: got %h", $time, rx_got);
                errors++;
            end
            else
            begin
                rx_want = pending_results.pop_front();
                if (rx_got.start_frame !== rx_want.start_frame)
                    note_mismatch("start_frame", rx_want.start_frame, rx_got.start_frame);
                if (rx_got.end_frame !== rx_want.end_frame)
                    note_mismatch("end_frame", rx_want.end_frame, rx_got.end_frame);
                if (rx_got.clip_length !== rx_want.clip_length)
                    note_mismatch("clip_length", rx_want.clip_length, rx_got.clip_length);
                if (rx_got.frame_total !== rx_want.frame_total)
                    note_mismatch("frame_total", rx_want.frame_total, rx_got.frame_total);
            end
        end
    end

    // Watchdog on cycles with no accepted beat or register access
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t watchdog: no progress, %0d results outstanding",
                         $time, pending_results.size());
                $display("tb_top NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_clip_state();
        @(posedge rst_n);
        @(posedge clk);
        test_reset_values();
        test_directed();
        test_geometry_extremes();
        test_frame_limit();
        test_random(13, 80, 370);
        test_random(80, 13, 370);
        test_random(0, 0, 370);
        settle();
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
